@@ sv/pflb_pkg.sv @@
`default_nettype none
package pflb_pkg;

  localparam int unsigned DEF_MAX_SLOTS  = 16;
  localparam int unsigned DEF_SLOT_BYTES = 32 * 1024;
  localparam int unsigned DEF_MAX_FLOWS  = 1024;
  localparam int unsigned REC_HDR        = 16;

  localparam int unsigned IN_W  = 96;
  localparam int unsigned OUT_W = 344;

  // configuration register indexes
  localparam logic REG_ACT_SLOTS = 1'b0;
  localparam logic REG_ACT_FLOWS = 1'b1;

  typedef enum logic [1:0] {
    KIND_FLUSH  = 2'd0,
    KIND_PLACE  = 2'd1,
    KIND_DIRECT = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_ZERO  = 2'd1,
    ERR_RANGE = 2'd2
  } err_e;

  typedef struct packed {
    logic [63:0] tot;
    logic [31:0] link;
    logic [63:0] ob;
    logic [63:0] cb;
    logic [63:0] pc;
    err_e        err;
    logic [16:0] cnt;
    logic [14:0] off;
    logic [9:0]  flow;
    logic [3:0]  slot;
    kind_e       kind;
  } res_t;

endpackage
`default_nettype wire

@@ sv/per_flow_lru_buffer_slot_manager.sv @@
// Per-flow buffer slot manager with least-recently-touched replacement.
//
// Input stream (s_axis_*): one packet request per item, carrying the 1-based
// flow owner, captured length, on-wire length and link type. Output stream
// (m_axis_*): one or two results per request: an optional slot flush followed
// by a buffered placement or a direct write, or a single error result.
// tlast marks the final result of a request.
//
// Timing: the flow table read happens at acceptance and is followed by a scan of
// every slot register, one slot per cycle, for the free and least-recently-touched
// search; a select step and a read-modify-write step follow. The first result is
// presented after these steps, then one result per cycle while the receiver takes
// them. tready returns in the cycle after the last result is taken. Errors are
// presented in the cycle after acceptance. One request is in work at a time.
// Reset: slot registers clear at once; the flow table (MAX_FLOWS entries)
// is then cleared one entry per cycle, with no request taken.
// Receiver stall: the result holds on m_axis_tdata until tready rises.
`default_nettype none
module per_flow_lru_buffer_slot_manager
  import pflb_pkg::*;
#(
  parameter int unsigned MAX_SLOTS  = DEF_MAX_SLOTS,
  parameter int unsigned SLOT_BYTES = DEF_SLOT_BYTES,
  parameter int unsigned MAX_FLOWS  = DEF_MAX_FLOWS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_index_i,
  input  wire logic [10:0]       cfg_data_i,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // owner id[10:0], captured bytes[26:11], wire bytes[58:27],
  // link kind[90:59], zero pad
  input  wire logic [IN_W-1:0]   s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // kind, slot, flow, offset, byte count, error code,
  // flow_packet_count, flow_captured_bytes, flow_original_bytes, flow_link,
  // total_packets, zero pad (lowest bit up)
  output logic [OUT_W-1:0]       m_axis_tdata,
  output logic                   m_axis_tlast
);

  localparam int unsigned SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned FW  = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
  localparam int unsigned FLW = $clog2(SLOT_BYTES + 1);

  typedef struct packed {
    logic          has;
    logic [SW-1:0] slot;
    logic          seen;
    logic [63:0]   pc;
    logic [63:0]   cb;
    logic [63:0]   ob;
  } flow_ent_t;

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_SCAN = 6'b000100,
    S_SEL  = 6'b001000,
    S_EXEC = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [4:0]  act_slots_q;
  logic [10:0] act_flows_q;

  // slot registers
  logic [MAX_SLOTS-1:0] slot_valid_q;
  logic [FW-1:0]        slot_owner_q [MAX_SLOTS];
  logic [FLW-1:0]       slot_fill_q  [MAX_SLOTS];
  logic [63:0]          slot_touch_q [MAX_SLOTS];
  logic [63:0]          touch_cnt_q;
  logic [63:0]          pkt_total_q;

  // flow table and link table
  flow_ent_t   flow_mem [MAX_FLOWS];
  logic [31:0] link_mem [MAX_FLOWS];
  flow_ent_t   flow_rd_q;
  logic [31:0] link_rd_q;

  logic [FW-1:0] clr_q;

  // request registers
  logic [FW-1:0] f_q;
  logic [16:0]   rec_q;
  logic [15:0]   cap_q;
  logic [31:0]   orig_q;
  logic [31:0]   link_q;

  logic [SW-1:0] scan_q;
  logic          found_q, bound_q;
  logic [SW-1:0] free_q, lru_q, s_q;
  logic          evict_q;

  res_t r0_q, r1_q;
  logic two_q, sel_q;

  // input fields
  logic [10:0] in_owner;
  logic [15:0] in_cap;
  logic [31:0] in_orig, in_link;
  assign in_owner = s_axis_tdata[10:0];
  assign in_cap   = s_axis_tdata[26:11];
  assign in_orig  = s_axis_tdata[58:27];
  assign in_link  = s_axis_tdata[90:59];

  logic [31:0] nflows;
  logic [SW-1:0] nslots_m1;
  always_comb begin
    if (act_flows_q == 11'd0) begin
      nflows = 32'd1;
    end else if (32'(act_flows_q) > MAX_FLOWS) begin
      nflows = MAX_FLOWS;
    end else begin
      nflows = 32'(act_flows_q);
    end
    if (act_slots_q == 5'd0) begin
      nslots_m1 = '0;
    end else if (32'(act_slots_q) > MAX_SLOTS) begin
      nslots_m1 = SW'(MAX_SLOTS - 1);
    end else begin
      nslots_m1 = SW'(act_slots_q - 5'd1);
    end
  end

  logic in_acc, out_acc, err_zero, err_range;
  logic [FW-1:0] in_f;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign err_zero      = (in_owner == 11'd0);
  assign err_range     = !err_zero && (32'(in_owner) > nflows);
  assign in_f          = FW'(in_owner - 11'd1);

  // error answer for a rejected owner id
  res_t err_r;
  always_comb begin
    err_r      = '0;
    err_r.kind = KIND_ERROR;
    err_r.err  = err_zero ? ERR_ZERO : ERR_RANGE;
    err_r.tot  = pkt_total_q;
  end

  // read-modify-write decision for the request
  logic [FLW-1:0] fill_s, base, place_off;
  logic [FW-1:0]  own_s;
  logic           big, flush, flush2, evict_flush;
  logic [63:0]    new_pc, new_cb, new_ob, new_tot, new_touch;
  logic [31:0]    out_link;
  res_t           flush_r, main_r;
  flow_ent_t      flow_wr;

  always_comb begin
    fill_s      = slot_fill_q[s_q];
    own_s       = slot_owner_q[s_q];
    big         = 32'(rec_q) > SLOT_BYTES;
    base        = bound_q ? fill_s : '0;
    evict_flush = evict_q && (fill_s != '0);
    flush2      = (32'(base) + 32'(rec_q) > SLOT_BYTES) && (base != '0);
    place_off   = flush2 ? '0 : base;
    new_pc      = flow_rd_q.pc + 64'd1;
    new_cb      = flow_rd_q.cb + 64'(cap_q);
    new_ob      = flow_rd_q.ob + 64'(orig_q);
    new_tot     = pkt_total_q + 64'd1;
    new_touch   = touch_cnt_q + ((big) ? 64'd1 : 64'd2);
    out_link    = flow_rd_q.seen ? link_rd_q : link_q;

    flush_r      = '0;
    flush_r.kind = KIND_FLUSH;
    flush_r.err  = ERR_NONE;
    flush_r.slot = 4'(s_q);
    flush_r.cnt  = 17'(fill_s);
    flush_r.flow = 10'(f_q);
    flush_r.pc   = new_pc;
    flush_r.cb   = new_cb;
    flush_r.ob   = new_ob;
    flush_r.link = out_link;
    flush_r.tot  = new_tot;
    main_r       = flush_r;
    main_r.cnt   = rec_q;
    if (big) begin
      flush = bound_q && (fill_s != '0);
      main_r.kind = KIND_DIRECT;
      main_r.slot = '0;
    end else begin
      flush = evict_flush || flush2;
      if (evict_flush) begin
        flush_r.flow = 10'(own_s);
      end
      main_r.kind = KIND_PLACE;
      main_r.off  = 15'(place_off);
    end

    flow_wr      = flow_rd_q;
    flow_wr.seen = 1'b1;
    flow_wr.pc   = new_pc;
    flow_wr.cb   = new_cb;
    flow_wr.ob   = new_ob;
    if (!big) begin
      flow_wr.has  = 1'b1;
      flow_wr.slot = s_q;
    end
  end

  // flow and link tables: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLR) begin
      flow_mem[clr_q] <= '0;
    end else if (state_q == S_EXEC) begin
      flow_mem[f_q] <= flow_wr;
      if (!flow_rd_q.seen) begin
        link_mem[f_q] <= link_q;
      end
    end
    if (in_acc) begin
      flow_rd_q <= flow_mem[in_f];
      link_rd_q <= link_mem[in_f];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      f_q    <= in_f;
      cap_q  <= in_cap;
      rec_q  <= 17'(in_cap) + 17'(REC_HDR);
      orig_q <= in_orig;
      link_q <= in_link;
    end
    if (state_q == S_SCAN) begin
      if ((scan_q <= nslots_m1) && !found_q && !slot_valid_q[scan_q]) begin
        free_q <= scan_q;
      end
      if ((scan_q == '0) ||
          ((scan_q <= nslots_m1) && (slot_touch_q[scan_q] < slot_touch_q[lru_q]))) begin
        lru_q <= scan_q;
      end
    end
    if (state_q == S_SEL) begin
      s_q     <= bound_q ? flow_rd_q.slot : (found_q ? free_q : lru_q);
      evict_q <= !bound_q && !found_q;
    end
    if (in_acc) begin
      r1_q <= err_r;
    end else if (state_q == S_EXEC) begin
      r0_q <= flush_r;
      r1_q <= main_r;
    end
  end

  // control
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:  if (clr_q == FW'(MAX_FLOWS - 1)) state_d = S_IDLE;
      S_IDLE: if (in_acc) state_d = (err_zero || err_range) ? S_OUT : S_SCAN;
      S_SCAN: if (scan_q == SW'(MAX_SLOTS - 1)) state_d = S_SEL;
      S_SEL:  state_d = S_EXEC;
      S_EXEC: state_d = S_OUT;
      S_OUT:  if (out_acc && m_axis_tlast) state_d = S_IDLE;
      default: state_d = S_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      act_slots_q  <= 5'd16;
      act_flows_q  <= 11'd1024;
      slot_valid_q <= '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_owner_q[i] <= '0;
        slot_fill_q[i]  <= '0;
        slot_touch_q[i] <= '0;
      end
      touch_cnt_q  <= '0;
      pkt_total_q  <= '0;
      clr_q        <= '0;
      scan_q       <= '0;
      found_q      <= 1'b0;
      bound_q      <= 1'b0;
      two_q        <= 1'b0;
      sel_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ACT_SLOTS: act_slots_q <= cfg_data_i[4:0];
          REG_ACT_FLOWS: act_flows_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_CLR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (in_acc) begin
        scan_q  <= '0;
        found_q <= 1'b0;
        bound_q <= 1'b0;
        two_q   <= 1'b0;
        sel_q   <= 1'b0;
      end
      if (state_q == S_SCAN) begin
        scan_q <= scan_q + 1'b1;
        if ((scan_q <= nslots_m1) && !slot_valid_q[scan_q]) begin
          found_q <= 1'b1;
        end
        // the flow still owns its recorded slot unless it was taken over
        if (flow_rd_q.has && (scan_q == flow_rd_q.slot) && slot_valid_q[scan_q] &&
            (slot_owner_q[scan_q] == f_q)) begin
          bound_q <= 1'b1;
        end
      end
      if (state_q == S_EXEC) begin
        two_q       <= flush;
        pkt_total_q <= new_tot;
        if (big) begin
          if (bound_q) begin
            slot_fill_q[s_q]  <= '0;
            slot_touch_q[s_q] <= new_touch;
            touch_cnt_q       <= new_touch;
          end
        end else begin
          slot_valid_q[s_q] <= 1'b1;
          slot_owner_q[s_q] <= f_q;
          slot_fill_q[s_q]  <= FLW'(32'(place_off) + 32'(rec_q));
          slot_touch_q[s_q] <= new_touch;
          touch_cnt_q       <= new_touch;
        end
      end
      if (out_acc && !m_axis_tlast) begin
        sel_q <= 1'b1;
      end
    end
  end

  res_t out_r;
  assign out_r         = (two_q && !sel_q) ? r0_q : r1_q;
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tlast  = !(two_q && !sel_q);
  assign m_axis_tdata  = {6'b0, out_r};

  // no request is taken while the flow table is being cleared
  a_clr_block : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !s_axis_tready)
    else $error("request taken during flow table clear");

  // one request at a time: nothing new right after an acceptance
  a_one_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("second request taken while one is in work");

  // the last result of a request closes the output
  a_last_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("result after last");

  // a request produces no result while the slot scan runs
  a_no_early : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !m_axis_tvalid)
    else $error("result during slot scan");

endmodule
`default_nettype wire
